### sv/sle_pkg.sv
// ----------------------------------------------------------------------------
// sle_pkg: shared types and constants of the sequential list engine
// Item structs, operation and status codes, word conversion helpers.
// ----------------------------------------------------------------------------
package sle_pkg;

  localparam int CAPACITY   = 256;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int POS_W      = 9;
  localparam int TGT_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

  // operation codes
  localparam logic [2:0] OP_APPEND    = 3'd0;
  localparam logic [2:0] OP_REMOVE    = 3'd1;
  localparam logic [2:0] OP_FIND      = 3'd2;
  localparam logic [2:0] OP_INSERT    = 3'd3;
  localparam logic [2:0] OP_READ_AT   = 3'd4;
  localparam logic [2:0] OP_READ_LAST = 3'd5;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;

  typedef logic signed [DATA_WIDTH-1:0] sle_word_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
    logic [POS_W-1:0]   position;
  } sle_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_out;
    logic [7:0]         found_index;
    logic [8:0]         count;
  } sle_out_t;

  // control toward the cell row
  typedef struct packed {
    logic      shift;
    sle_word_t feed;
  } sle_ring_t;

  function automatic sle_word_t to_word(input logic signed [31:0] v);
    return DATA_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] word_out(input sle_word_t w);
    return 32'(w);
  endfunction

endpackage

### sv/sequential_list_engine.sv
// ----------------------------------------------------------------------------
// sequential_list_engine: fixed-capacity ordered list of signed words
// Append, remove last, find, insert at, read at and read last, one item at a
// time, each answered by one result item.
// ----------------------------------------------------------------------------
// The list lives in a ring of CAPACITY word cells. Append, find, insert and
// both reads rotate the whole ring once, one shift per cell, during which
// cell 0 shows old entry k at step k while the far end of the ring takes the
// new entry k (an insert feeds the old words up to the position, then the new
// word, then each old word delayed by one register). The item is taken in
// the idle state, the ring is walked in the walk state and the result is
// loaded into the output register in the finish state. Remove last,
// requests refused up front (full, empty, bad position, find on an empty
// list) and the unused operation codes skip the walk and go straight to
// the finish state. in_stall stays high from acceptance until the result
// is loaded into the output register; a result that waits on out_stall
// holds the block in its final state. Entries are undefined after reset
// and need no clearing pass: only entries below the count are ever read.
// ----------------------------------------------------------------------------
module sequential_list_engine
  import sle_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  sle_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output sle_out_t out_data
);

  sle_word_t cell_q [CAPACITY];
  sle_ring_t ring;

  sle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .head      (cell_q[0]),
    .ring      (ring)
  );

  // cell k takes cell k+1; the last cell takes the sequencer's feed word
  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    if (k == CAPACITY - 1) begin : g_tail
      sle_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d_in  (ring.feed),
        .q     (cell_q[k])
      );
    end else begin : g_body
      sle_cell u_cell (
        .clk   (clk),
        .shift (ring.shift),
        .d_in  (cell_q[k+1]),
        .q     (cell_q[k])
      );
    end
  end

endmodule

### sv/sle_cell.sv
// ----------------------------------------------------------------------------
// sle_cell: one storage cell of the list ring
// Holds one word and takes its input word (the neighbor's, or the feed at the tail) on every shift.
// ----------------------------------------------------------------------------
module sle_cell
  import sle_pkg::*;
(
  input  logic      clk,
  input  logic      shift,
  input  sle_word_t d_in,
  output sle_word_t q
);

  sle_word_t word_r;

  always_ff @(posedge clk) begin
    if (shift) begin
      word_r <= d_in;
    end
  end

  assign q = word_r;

endmodule

### sv/sle_ctrl.sv
// ----------------------------------------------------------------------------
// sle_ctrl: sequencer of the list engine
// Decodes an item, walks the ring once when needed, feeds the tail, builds the result.
// ----------------------------------------------------------------------------
module sle_ctrl
  import sle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  sle_in_t   in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output sle_out_t  out_data,
  input  sle_word_t head,
  output sle_ring_t ring
);

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_FINISH} state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic [TGT_W-1:0] tgt_r, tgt_nxt;
  sle_word_t        word_r, word_nxt;
  sle_word_t        prev_r, prev_nxt;
  logic             find_r, find_nxt;
  logic             rd_r, rd_nxt;
  logic             wr_r, wr_nxt;
  logic             grow_r, grow_nxt;
  logic             shrink_r, shrink_nxt;
  logic [2:0]       status_r, status_nxt;
  logic signed [31:0] data_r, data_nxt;
  logic [7:0]       found_r, found_nxt;
  logic             out_valid_r, out_valid_nxt;
  sle_out_t         out_r, out_nxt;
  logic [TGT_W-1:0] step_t;
  logic [CNT_W-1:0] count_new;

  assign in_stall = (state_r != S_IDLE);
  assign step_t   = TGT_W'(step_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    tgt_nxt       = tgt_r;
    word_nxt      = word_r;
    prev_nxt      = prev_r;
    find_nxt      = find_r;
    rd_nxt        = rd_r;
    wr_nxt        = wr_r;
    grow_nxt      = grow_r;
    shrink_nxt    = shrink_r;
    status_nxt    = status_r;
    data_nxt      = data_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ring.shift    = 1'b0;
    ring.feed     = head;
    count_new     = count_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          find_nxt   = 1'b0;
          rd_nxt     = 1'b0;
          wr_nxt     = 1'b0;
          grow_nxt   = 1'b0;
          shrink_nxt = 1'b0;
          status_nxt = ST_OK;
          data_nxt   = '0;
          found_nxt  = '0;
          step_nxt   = '0;
          tgt_nxt    = TGT_W'(in_data.position);
          word_nxt   = to_word(in_data.value);
          state_nxt  = S_FINISH;
          unique case (in_data.operation)
            OP_APPEND: begin
              if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_nxt    = 1'b1;
                grow_nxt  = 1'b1;
                tgt_nxt   = TGT_W'(count_r);
                state_nxt = S_WALK;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                shrink_nxt = 1'b1;
              end
            end
            OP_FIND: begin
              status_nxt = ST_MISSING;
              if (count_r != '0) begin
                find_nxt  = 1'b1;
                state_nxt = S_WALK;
              end
            end
            OP_INSERT: begin
              if (TGT_W'(in_data.position) > TGT_W'(count_r)) begin
                status_nxt = ST_RANGE;
              end else if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                wr_nxt    = 1'b1;
                grow_nxt  = 1'b1;
                state_nxt = S_WALK;
              end
            end
            OP_READ_AT: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else if (TGT_W'(in_data.position) >= TGT_W'(count_r)) begin
                status_nxt = ST_RANGE;
              end else begin
                rd_nxt    = 1'b1;
                state_nxt = S_WALK;
              end
            end
            OP_READ_LAST: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                rd_nxt    = 1'b1;
                tgt_nxt   = TGT_W'(count_r - 1'b1);
                state_nxt = S_WALK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_WALK: begin
        // head shows old entry step_r; the tail takes new entry step_r
        ring.shift = 1'b1;
        if (wr_r) begin
          if (step_t < tgt_r) begin
            ring.feed = head;
          end else if (step_t == tgt_r) begin
            ring.feed = word_r;
          end else begin
            ring.feed = prev_r;
          end
        end
        prev_nxt = head;
        if (find_r && (step_t < TGT_W'(count_r)) && (head == word_r)) begin
          find_nxt   = 1'b0;
          status_nxt = ST_OK;
          found_nxt  = 8'(step_r);
        end
        if (rd_r && (step_t == tgt_r)) begin
          data_nxt = word_out(head);
        end
        step_nxt = step_r + 1'b1;
        if (step_r == IDX_W'(CAPACITY - 1)) begin
          step_nxt  = '0;
          state_nxt = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          if (grow_r) begin
            count_new = count_r + 1'b1;
          end else if (shrink_r) begin
            count_new = count_r - 1'b1;
          end
          count_nxt           = count_new;
          out_valid_nxt       = 1'b1;
          out_nxt.status      = status_r;
          out_nxt.data_out    = data_r;
          out_nxt.found_index = found_r;
          out_nxt.count       = 9'(count_new);
          state_nxt           = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
    tgt_r    <= tgt_nxt;
    word_r   <= word_nxt;
    prev_r   <= prev_nxt;
    find_r   <= find_nxt;
    rd_r     <= rd_nxt;
    wr_r     <= wr_nxt;
    grow_r   <= grow_nxt;
    shrink_r <= shrink_nxt;
    status_r <= status_nxt;
    data_r   <= data_nxt;
    found_r  <= found_nxt;
    out_r    <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### sv/sle_checker.sv
// ----------------------------------------------------------------------------
// sle_checker: port-level checks of the list engine
// Result hold, one item in flight, and status consistency of results.
// ----------------------------------------------------------------------------
module sle_checker
  import sle_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input logic     out_valid,
  input logic     out_stall,
  input sle_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item taken while one is in work");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_EMPTY) |-> (out_data.count == 9'd0))
    else $error("empty status with nonzero count");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_FULL) |-> (out_data.count == 9'(CAPACITY)))
    else $error("full status below capacity");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK)
      |-> (out_data.data_out == 32'sd0) && (out_data.found_index == 8'd0))
    else $error("refused request carries data");

endmodule

bind sequential_list_engine sle_checker u_sle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

### tb/sequential_list_engine_test.sv
// ----------------------------------------------------------------------------
// sequential_list_engine_test: self-checking bench for the list engine
// Drives list requests through the valid/stall input channel and checks
// every answer on the output channel against a shadow copy of the list that
// is updated as each item is accepted. A short directed table opens the
// run; biased random phases then fill the list to capacity, hold it there,
// drain it, hold it empty, and finish with a free random walk.
// ----------------------------------------------------------------------------
module sequential_list_engine_test;
  import sle_pkg::*;

  // Codes the block must ignore.
  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  localparam int unsigned ITEM_GOAL  = 1300;
  localparam int unsigned MAX_GAP    = 13;
  // The limit allows several times the length of the whole run, even with
  // the widest input gap and output stall.
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned SETTLE      = CAPACITY + 16;

  typedef enum int {FILLING, AT_CAPACITY, DRAINING, AT_EMPTY, MIXING} phase_t;

  typedef struct {
    sle_in_t  req;
    bit       typed;
    sle_out_t ans;
  } list_row_t;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  sle_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sle_out_t out_data;

  sequential_list_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Shadow of the list: words and length as the block should hold them
  // once every accepted item has been applied.
  sle_word_t   shadow_words [CAPACITY];
  int          shadow_len = 0;
  int          peak_len   = 0;

  sle_out_t    pending_answers [$];
  list_row_t   directed_rows [$];
  sle_out_t    head_answer;

  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;
  int unsigned random_items   = 0;
  int unsigned answers_seen   = 0;
  int unsigned status_tally [8];

  // Idle pacing; each side flips in and out of a no-idle stretch.
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  int unsigned out_hold  = 0;

  logic signed [31:0] corner_words [4] = '{32'sh7fffffff, 32'sh80000000, 32'sh0, -32'sd1};

  // --------------------------------------------------------------------------
  // Shadow list update: applies one request, returns the answer it owes.
  // --------------------------------------------------------------------------
  function automatic sle_out_t apply_list_op(sle_in_t req);
    sle_out_t  ans;
    sle_word_t w;
    int        pos;
    int        i;
    ans = '0;
    w   = sle_word_t'(req.value);
    pos = int'(req.position);
    case (req.operation)
      OP_APPEND: begin
        if (shadow_len >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          shadow_words[shadow_len] = w;
          shadow_len++;
        end
      end
      OP_REMOVE: begin
        if (shadow_len == 0) ans.status = ST_EMPTY;
        else shadow_len--;
      end
      OP_FIND: begin
        // first match wins
        ans.status = ST_MISSING;
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_words[i] == w) begin
            ans.status      = ST_OK;
            ans.found_index = 8'(i);
            break;
          end
        end
      end
      OP_INSERT: begin
        // position equal to the length is an append
        if (pos > shadow_len) begin
          ans.status = ST_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          ans.status = ST_FULL;
        end else begin
          for (i = shadow_len; i > pos; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[pos] = w;
          shadow_len++;
        end
      end
      OP_READ_AT: begin
        if (shadow_len == 0) ans.status = ST_EMPTY;
        else if (pos >= shadow_len) ans.status = ST_RANGE;
        else ans.data_out = shadow_words[pos];
      end
      OP_READ_LAST: begin
        if (shadow_len == 0) ans.status = ST_EMPTY;
        else ans.data_out = shadow_words[shadow_len-1];
      end
      default: begin
        // spare codes: no change, status ok
      end
    endcase
    ans.count = 9'(shadow_len);
    return ans;
  endfunction

  // --------------------------------------------------------------------------
  // Random request shaping
  // --------------------------------------------------------------------------
  function automatic logic signed [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    // small values repeat often, which exercises first-match on find
    if (r < 25) return 32'(int'($urandom_range(0, 16)) - 8);
    if (r < 35) return corner_words[$urandom_range(0, 3)];
    return $urandom;
  endfunction

  // Each phase tilts the mix between growing and shrinking requests so the
  // list spends time full, empty and everywhere between.
  function automatic sle_in_t make_request(phase_t ph);
    sle_in_t     req;
    int unsigned r, pick, sel, grow_pct, shrink_pct;
    case (ph)
      FILLING:     begin grow_pct = 70; shrink_pct = 5;  end
      AT_CAPACITY: begin grow_pct = 45; shrink_pct = 8;  end
      DRAINING:    begin grow_pct = 10; shrink_pct = 55; end
      AT_EMPTY:    begin grow_pct = 8;  shrink_pct = 40; end
      default:     begin grow_pct = 35; shrink_pct = 30; end
    endcase
    req.value    = pick_value();
    req.position = 9'($urandom_range(0, 511));
    r    = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (r < 3) begin
      req.operation = $urandom_range(0, 1) ? OP_SPARE_HI : OP_SPARE_LO;
    end else if (r < 3 + shrink_pct) begin
      req.operation = OP_REMOVE;
    end else if (r < 3 + shrink_pct + grow_pct) begin
      if (pick < 60) begin
        req.operation = OP_APPEND;
      end else begin
        req.operation = OP_INSERT;
        // mostly legal positions, some at the tail, the rest anywhere
        if (pick < 90) req.position = 9'($urandom_range(0, shadow_len));
        else if (pick < 95) req.position = 9'(shadow_len);
      end
    end else begin
      sel = $urandom_range(0, 4);
      if (sel < 2) begin
        req.operation = OP_FIND;
        if (shadow_len != 0 && pick < 70)
          req.value = shadow_words[$urandom_range(0, shadow_len - 1)];
      end else if (sel < 4) begin
        req.operation = OP_READ_AT;
        if (shadow_len != 0 && pick < 85)
          req.position = (pick < 15) ? 9'd0 : 9'($urandom_range(0, shadow_len - 1));
      end else begin
        req.operation = OP_READ_LAST;
      end
    end
    return req;
  endfunction

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 24) == 0) send_calm = !send_calm;
    return send_calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int unsigned draw_hold();
    if ($urandom_range(0, 24) == 0) recv_calm = !recv_calm;
    return recv_calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  // --------------------------------------------------------------------------
  // Input side. Tasks are entered and left on a falling edge.
  // --------------------------------------------------------------------------
  task automatic send_item(sle_in_t req, bit typed, sle_out_t typed_ans);
    int unsigned gap;
    sle_out_t    ans;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    // accepted at the first rising edge with stall low
    do @(posedge clk); while (in_stall);
    ans = apply_list_op(req);
    // typed rows carry their own answer; the shadow still tracks the state
    pending_answers.push_back(typed ? typed_ans : ans);
    items_sent++;
    if (shadow_len > peak_len) peak_len = shadow_len;
    @(negedge clk);
  endtask

  // Hold the input idle until every owed answer is back.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_answers.size() != 0);
  endtask

  task automatic run_phase(phase_t ph, int unsigned budget);
    int unsigned used;
    sle_in_t     req;
    used = 0;
    while (used < budget && !(ph == FILLING && shadow_len == CAPACITY)
           && !(ph == DRAINING && shadow_len == 0)) begin
      req = make_request(ph);
      send_item(req, 1'b0, '0);
      if (req.operation <= OP_READ_LAST) begin
        used++;
        random_items++;
      end
    end
    wait_quiet();
  endtask

  task automatic add_row(logic [2:0] op, logic [31:0] value, int pos, bit typed,
                         logic [2:0] st, logic [31:0] data, int idx, int cnt);
    list_row_t row;
    row.req.operation   = op;
    row.req.value       = value;
    row.req.position    = 9'(pos);
    row.typed           = typed;
    row.ans.status      = st;
    row.ans.data_out    = data;
    row.ans.found_index = 8'(idx);
    row.ans.count       = 9'(cnt);
    directed_rows.push_back(row);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned k;

    // op, value, position, typed?, status, data, found index, count
    // empty list: every read and remove is refused
    add_row(OP_READ_LAST, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    add_row(OP_REMOVE, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    add_row(OP_READ_AT, 0, 0, 1, ST_EMPTY, 0, 0, 0);
    add_row(OP_FIND, 5, 0, 1, ST_MISSING, 0, 0, 0);
    add_row(OP_INSERT, 9, 1, 1, ST_RANGE, 0, 0, 0);
    // build max, 0, min, -1
    add_row(OP_INSERT, 32'h7fffffff, 0, 1, ST_OK, 0, 0, 1);
    add_row(OP_APPEND, 32'h80000000, 0, 1, ST_OK, 0, 0, 2);
    add_row(OP_APPEND, 32'hffffffff, 0, 1, ST_OK, 0, 0, 3);
    add_row(OP_INSERT, 0, 1, 1, ST_OK, 0, 0, 4);
    add_row(OP_READ_AT, 0, 0, 1, ST_OK, 32'h7fffffff, 0, 4);
    add_row(OP_READ_AT, 0, 2, 1, ST_OK, 32'h80000000, 0, 4);
    // read at the count and at the widest position
    add_row(OP_READ_AT, 0, 4, 1, ST_RANGE, 0, 0, 4);
    add_row(OP_READ_AT, 0, 511, 1, ST_RANGE, 0, 0, 4);
    // insert past the count refused, at the count appends
    add_row(OP_INSERT, 1, 5, 1, ST_RANGE, 0, 0, 4);
    add_row(OP_INSERT, 17, 4, 1, ST_OK, 0, 0, 5);
    add_row(OP_READ_LAST, 0, 0, 1, ST_OK, 17, 0, 5);
    add_row(OP_FIND, 32'hffffffff, 0, 1, ST_OK, 0, 3, 5);
    // duplicate: find returns the first copy
    add_row(OP_APPEND, 17, 0, 0, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 17, 0, 0, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 12345, 0, 1, ST_MISSING, 0, 0, 6);
    // spare codes leave the list alone
    add_row(OP_SPARE_LO, 0, 0, 1, ST_OK, 0, 0, 6);
    add_row(OP_SPARE_HI, 32'hffffffff, 511, 1, ST_OK, 0, 0, 6);
    add_row(OP_REMOVE, 0, 0, 1, ST_OK, 0, 0, 5);
    add_row(OP_READ_AT, 0, 1, 0, ST_OK, 0, 0, 0);
    add_row(OP_FIND, 32'h7fffffff, 0, 0, ST_OK, 0, 0, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (k = 0; k < directed_rows.size(); k++)
      send_item(directed_rows[k].req, directed_rows[k].typed, directed_rows[k].ans);
    wait_quiet();

    // Each phase ends with the input held until all answers are in.
    run_phase(FILLING, 700);
    run_phase(AT_CAPACITY, 40);
    run_phase(DRAINING, 800);
    run_phase(AT_EMPTY, 30);
    run_phase(MIXING, (random_items < ITEM_GOAL) ? ITEM_GOAL - random_items : 50);

    // drained above; let a full walk pass so a stray answer would show
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("%0d items sent (%0d random), %0d answers checked, peak length %0d, %0d cycles",
             items_sent, random_items, answers_seen, peak_len, cycle_count);
    $display("answers ok/full/empty/range/missing: %0d/%0d/%0d/%0d/%0d",
             status_tally[ST_OK], status_tally[ST_FULL], status_tally[ST_EMPTY],
             status_tally[ST_RANGE], status_tally[ST_MISSING]);
    if (mismatch_count == 0 && pending_answers.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Output side
  // --------------------------------------------------------------------------
  // Stall: while an answer is offered it waits out the drawn hold; between
  // answers stall toggles at random so it also lands during the walk.
  always @(negedge clk) begin
    if (out_valid) begin
      out_stall <= (out_hold > 0);
      if (out_hold > 0) out_hold--;
    end else begin
      out_stall <= recv_calm ? 1'b0 : 1'($urandom_range(0, 1));
    end
  end

  task automatic report_mismatch(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  task automatic check_field(string name, logic [31:0] want_v, logic [31:0] got_v);
    if (got_v !== want_v)
      report_mismatch($sformatf("%s expected %h got %h", name, want_v, got_v));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer with none owed: %p", out_data));
      end else begin
        head_answer = pending_answers.pop_front();
        status_tally[head_answer.status]++;
        check_field("status", 32'(head_answer.status), 32'(out_data.status));
        check_field("data_out", head_answer.data_out, out_data.data_out);
        check_field("found_index", 32'(head_answer.found_index), 32'(out_data.found_index));
        check_field("count", 32'(head_answer.count), 32'(out_data.count));
      end
      out_hold = draw_hold();
    end
  end

  // Watchdog
  initial begin : watchdog
    do begin
      @(posedge clk);
      cycle_count++;
    end while (cycle_count < CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d answers still owed",
             cycle_count, pending_answers.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
